@@ sv/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants of the 3x3 binary contour extractor: pixel
// classes, command and register codes, field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = 12;
    localparam int CLS_W     = 2;
    localparam int DIM_RESET = 512;

    localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BG = 8'd0;

    typedef enum logic [CLS_W-1:0] {
        CLS_OTHER = 2'd0,
        CLS_BG    = 2'd1,
        CLS_FG    = 2'd2
    } cls_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    // Map a gray value to its class
    function automatic cls_t classify(input logic [PIX_W-1:0] pix);
        cls_t cls;
        cls = CLS_OTHER;
        if (pix == PIX_BG)
        begin
            cls = CLS_BG;
        end
        else if (pix == PIX_FG)
        begin
            cls = CLS_FG;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

@@ sv/bce_ram.sv @@
// ----------------------------------------------------------------------------
// bce_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/binary_contour_extract_3x3.sv @@
// ----------------------------------------------------------------------------
// binary_contour_extract_3x3
// 8-neighbour boundary extraction on a raster stream of gray pixels: a pixel
// of exactly 255 with a neighbour of exactly 0 inside the frame gives 255.
//
//   channel | dir | tdata                 | tuser        | tlast
//   s_      | in  | [7:0] pixel           | [0] command  | -
//   m_      | out | [7:0] contour         | -            | frame_last
//   cfg_    | in  | [10:0] width / height | index 0 / 1  | -
//
// One word per cycle while no stall or second drain shift holds s_tready.
// On accept the line RAM is read into the window stage; when that stage fires
// it writes the line back and loads the output register. The window trails
// input by one line plus one pixel.
// The single line RAM port pair sets the rate; the first drain word of a
// one-line frame takes two window shifts.
// Reset clears counters and valid flags and loads the default dimensions;
// line RAM contents are undefined until written and no clearing pass runs.
// A stalled output register holds the window stage and with it s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_contour_extract_3x3
    import bce_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // slave stream
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [PIX_W-1:0] s_tdata,   // [7:0] pixel
    input  wire logic             s_tuser,   // [0] command
    // master stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [PIX_W-1:0] m_tdata,   // [7:0] contour
    output logic                  m_tlast,
    // configuration
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int RAM_W  = 2 * CLS_W;
    localparam logic [CFG_W-1:0] WIDTH_RST =
        CFG_W'((MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET);
    localparam logic [CFG_W-1:0] HEIGHT_RST =
        CFG_W'((MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET);

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                    input int maxv);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (32'(v) > maxv)
        begin
            r = CFG_W'(maxv);
        end
        return r;
    endfunction

    // Configuration and frame counters
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CNT_W-1:0] in_col_reg, in_col_next;
    logic [CNT_W-1:0] in_row_reg, in_row_next;
    logic [CNT_W-1:0] out_col_reg, out_col_next;
    logic [CNT_W-1:0] out_row_reg, out_row_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    logic             extra_reg, extra_next;

    // Window stage
    logic              s1_valid_reg;
    logic              s1_res_reg;
    cls_t              s1_cls_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_top_reg, s1_bot_reg, s1_left_reg, s1_right_reg;
    logic              s1_last_reg;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [RAM_W-1:0]  fwd_data_reg;
    cls_t              win_reg  [3][3];
    cls_t              win_next [3][3];

    // Output register
    logic             m_tvalid_reg;
    logic [PIX_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    // Issue-side signals
    logic             accept, is_pix, pend_nz, restart_pre, drain_act;
    logic             issue, issue_ok, drain_issue, pos_valid;
    logic [CNT_W-1:0] col0, row0, ocol0, orow0, w_ext, h_ext;
    logic [CNT_W-1:0] col_inc, ocol_inc;
    logic             col_wrap, ocol_wrap;
    logic             iss_top, iss_bot, iss_left, iss_right, iss_last;
    logic [ADDR_W-1:0] issue_addr;
    cls_t             issue_cls;

    // Window-stage signals
    logic             s1_hold, s1_fire, hit;
    logic [RAM_W-1:0] ram_rd_data, rd_col, ram_wr_data;
    cls_t             col_up, col_lo;

    assign w_ext    = CNT_W'(width_reg);
    assign h_ext    = CNT_W'(height_reg);
    assign s1_hold  = s1_valid_reg && s1_res_reg && m_tvalid_reg && !m_tready;
    assign s1_fire  = s1_valid_reg && !s1_hold;
    assign issue_ok = !s1_hold;
    assign s_tready = issue_ok && !extra_reg;

    // Issue: classify, step the raster counters, track pending drains
    always_comb
    begin
        accept      = s_tvalid && s_tready;
        is_pix      = (cmd_t'(s_tuser) == CMD_PIXEL);
        pend_nz     = (pend_reg != '0);
        restart_pre = accept && is_pix && pend_nz;
        drain_act   = accept && !is_pix && pend_nz;
        drain_issue = drain_act || (extra_reg && issue_ok);
        issue       = (accept && is_pix) || drain_issue;
        issue_cls   = (accept && is_pix) ? classify(s_tdata) : CLS_OTHER;

        col0  = restart_pre ? '0 : in_col_reg;
        row0  = restart_pre ? '0 : in_row_reg;
        ocol0 = restart_pre ? '0 : out_col_reg;
        orow0 = restart_pre ? '0 : out_row_reg;

        pos_valid = (row0 >= CNT_W'(2)) || ((row0 == CNT_W'(1)) && (col0 != '0));
        col_inc   = col0 + CNT_W'(1);
        col_wrap  = (col_inc >= w_ext);
        ocol_inc  = ocol0 + CNT_W'(1);
        ocol_wrap = (ocol_inc >= w_ext);

        iss_top    = (orow0 == '0);
        iss_bot    = ((orow0 + CNT_W'(1)) >= h_ext);
        iss_left   = (ocol0 == '0);
        iss_right  = ocol_wrap;
        iss_last   = ((orow0 + CNT_W'(1)) == h_ext) && ocol_wrap;
        issue_addr = ADDR_W'(col0);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        extra_next   = extra_reg && !issue;

        if (issue)
        begin
            in_col_next  = col_wrap ? '0 : col_inc;
            in_row_next  = col_wrap ? row0 + CNT_W'(1) : row0;
            out_col_next = ocol0;
            out_row_next = orow0;
            if (pos_valid)
            begin
                out_col_next = ocol_wrap ? '0 : ocol_inc;
                out_row_next = ocol_wrap ? orow0 + CNT_W'(1) : orow0;
            end
        end

        // Frame complete: arm the drain count
        if (accept && is_pix)
        begin
            pend_next = '0;
            if (in_row_next >= h_ext)
            begin
                pend_next = (height_reg == CFG_W'(1)) ? w_ext : w_ext + CNT_W'(1);
            end
        end

        // Drain: one result per word, a second shift when the first is empty
        if (drain_issue)
        begin
            if (pos_valid)
            begin
                pend_next = pend_reg - CNT_W'(1);
                if (pend_reg == CNT_W'(1))
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
            else
            begin
                extra_next = 1'b1;
            end
        end
    end

    // Counter and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
            extra_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WIDTH:  width_reg  <= clamp_dim(cfg_data, MAX_WIDTH);
                REG_HEIGHT: height_reg <= clamp_dim(cfg_data, MAX_HEIGHT);
                default:    width_reg  <= width_reg;
            endcase
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
            extra_reg   <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
            extra_reg   <= extra_next;
        end
    end

    // Line RAM: upper row class in the high bits, lower in the low bits
    bce_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .we      (s1_fire),
        .wr_addr (s1_addr_reg),
        .wr_data (ram_wr_data),
        .re      (issue),
        .rd_addr (issue_addr),
        .rd_data (ram_rd_data)
    );

    // Window stage: forward a write that hit the same edge as our read
    always_comb
    begin
        rd_col       = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
        col_up       = cls_t'(rd_col[RAM_W-1:CLS_W]);
        col_lo       = cls_t'(rd_col[CLS_W-1:0]);
        ram_wr_data  = {col_lo, s1_cls_reg};
        fwd_hit_next = fwd_hit_reg && !s1_fire;
        if (issue)
        begin
            fwd_hit_next = s1_fire && (s1_addr_reg == issue_addr);
        end
    end

    // Shift the window one column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = col_up;
        win_next[1][2] = col_lo;
        win_next[2][2] = s1_cls_reg;
    end

    // Foreground centre with a background neighbour inside the frame
    always_comb
    begin
        logic skip;
        hit  = 1'b0;
        skip = 1'b0;
        if (win_next[1][1] == CLS_FG)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    skip = ((r == 1) && (c == 1)) ||
                           ((r == 0) && s1_top_reg) || ((r == 2) && s1_bot_reg) ||
                           ((c == 0) && s1_left_reg) || ((c == 2) && s1_right_reg);
                    if (!skip && (win_next[r][c] == CLS_BG))
                    begin
                        hit = 1'b1;
                    end
                end
            end
        end
    end

    // Window stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= fwd_hit_next;
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Window stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_res_reg   <= pos_valid;
            s1_cls_reg   <= issue_cls;
            s1_addr_reg  <= issue_addr;
            s1_top_reg   <= iss_top;
            s1_bot_reg   <= iss_bot;
            s1_left_reg  <= iss_left;
            s1_right_reg <= iss_right;
            s1_last_reg  <= iss_last;
            fwd_data_reg <= ram_wr_data;
        end
        if (s1_fire)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= win_next[r][c];
                end
            end
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s1_fire && s1_res_reg)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_res_reg)
        begin
            m_tdata_reg <= hit ? PIX_FG : PIX_BG;
            m_tlast_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // Drains are armed only once every line of the frame has come in
    a_pend_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != '0) |-> (in_row_reg >= h_ext))
        else $error("drain count armed before frame complete");

    // The second shift of a drain word only follows an armed drain
    a_extra_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        extra_reg |-> (pend_reg != '0))
        else $error("extra shift outside a drain");

    // Forwarded data belongs to a word in the window stage
    a_fwd_owner: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forward flag without window-stage word");

    // Output column stays inside the line
    a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_col_reg < w_ext)
        else $error("output column past line end");
`endif

endmodule

`default_nettype wire
